@@ sv/lhp_pkg.sv @@
`timescale 1ns / 1ps
// lhp_pkg: shared types, status codes, header flag masks and version limits
// for the lzop header parser; depends on nothing

package lhp_pkg;

  typedef enum logic [2:0] {
    ST_BUSY         = 3'd0,
    ST_DONE         = 3'd1,
    ST_BAD_MAGIC    = 3'd2,
    ST_BAD_VERSION  = 3'd3,
    ST_BAD_NEEDED   = 3'd4,
    ST_BAD_CHECKSUM = 3'd5
  } status_t;

  localparam logic [31:0] FL_ADLER_D = 32'h0000_0001;
  localparam logic [31:0] FL_ADLER_C = 32'h0000_0002;
  localparam logic [31:0] FL_EXTRA   = 32'h0000_0040;
  localparam logic [31:0] FL_CRC_D   = 32'h0000_0100;
  localparam logic [31:0] FL_CRC_C   = 32'h0000_0200;
  localparam logic [31:0] FL_FILTER  = 32'h0000_0800;

  localparam logic [15:0] MIN_VERSION    = 16'h0900;
  localparam logic [15:0] EXT_VERSION    = 16'h0940;
  localparam logic [15:0] DEFAULT_NEEDED = 16'h1030;

  localparam logic [3:0] MAGIC_LEN = 4'd9;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       restart;
  } in_beat_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] header_length;
    logic [31:0] header_flags;
    logic        block_has_checksum;
  } out_beat_t;

  // expected magic byte at a given offset of the signature
  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h89;
      4'd1:    b = 8'h4c;
      4'd2:    b = 8'h5a;
      4'd3:    b = 8'h4f;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h0d;
      4'd6:    b = 8'h0a;
      4'd7:    b = 8'h1a;
      4'd8:    b = 8'h0a;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ sv/lhp_in_if.sv @@
`timescale 1ns / 1ps
// lhp_in_if: valid/ready channel carrying one raw header byte per beat
// depends on nothing

interface lhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       restart;

  modport source (output valid, output header_byte, output restart, input ready);
  modport sink   (input valid, input header_byte, input restart, output ready);
endinterface

@@ sv/lhp_out_if.sv @@
`timescale 1ns / 1ps
// lhp_out_if: valid/ready channel carrying one parser result per beat
// depends on nothing

interface lhp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] header_length;
  logic [31:0] header_flags;
  logic        block_has_checksum;

  modport source (output valid, output status, output header_length,
                  output header_flags, output block_has_checksum, input ready);
  modport sink   (input valid, input status, input header_length,
                  input header_flags, input block_has_checksum, output ready);
endinterface

@@ sv/lhp_in_stage.sv @@
`timescale 1ns / 1ps
// lhp_in_stage: input register holding one byte beat ahead of the walker
// depends on lhp_pkg

module lhp_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lhp_pkg::in_beat_t in_beat,
  output logic             s1_valid,
  input  logic             s1_take,
  output lhp_pkg::in_beat_t s1_beat
);

  logic             valid_r;
  lhp_pkg::in_beat_t beat_r;

  // room when empty or when the held beat leaves this cycle
  assign in_ready = !valid_r || s1_take;
  assign s1_valid = valid_r;
  assign s1_beat  = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        valid_r <= 1'b1;
        beat_r  <= in_beat;
      end else if (s1_take) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ sv/lhp_walker.sv @@
`timescale 1ns / 1ps
// lhp_walker: header field sequencer and result register; one byte per beat
// depends on lhp_pkg

module lhp_walker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       max_needed,
  input  logic              s1_valid,
  input  lhp_pkg::in_beat_t  s1_beat,
  output logic              s1_take,
  output logic              out_valid,
  input  logic              out_ready,
  output lhp_pkg::out_beat_t out_beat
);

  typedef enum logic [4:0] {
    FS_MAGIC   = 5'd0,
    FS_VER     = 5'd1,
    FS_LIBVER  = 5'd2,
    FS_NEED    = 5'd3,
    FS_METHOD  = 5'd4,
    FS_LEVEL   = 5'd5,
    FS_FLAGS   = 5'd6,
    FS_FILTER  = 5'd7,
    FS_MODE    = 5'd8,
    FS_MTIME   = 5'd9,
    FS_MTIMEHI = 5'd10,
    FS_NAMELEN = 5'd11,
    FS_NAME    = 5'd12,
    FS_HCHK    = 5'd13,
    FS_XLEN    = 5'd14,
    FS_XDATA   = 5'd15,
    FS_XCHK    = 5'd16
  } step_t;

  step_t            field_step_r, field_step_nxt;
  logic [3:0]       byte_in_field_r, byte_in_field_nxt;
  logic [31:0]      skip_count_r, skip_count_nxt;
  logic [31:0]      field_shift_r, field_shift_nxt;
  logic [15:0]      version_word_r, version_word_nxt;
  logic [31:0]      flags_word_r, flags_word_nxt;
  logic [31:0]      consumed_r, consumed_nxt;
  lhp_pkg::status_t status_r, status_nxt;

  logic             out_valid_r;
  lhp_pkg::out_beat_t out_beat_r;

  // state as seen after an optional restart
  step_t            cur_step;
  logic [3:0]       cur_bif;
  logic [31:0]      cur_skip;
  logic [31:0]      cur_shift;
  logic [15:0]      cur_version;
  logic [31:0]      cur_flags;
  logic [31:0]      cur_consumed;
  lhp_pkg::status_t cur_status;

  logic [31:0] shift_cat;
  logic [3:0]  bif_inc;
  logic [3:0]  field_len;
  logic        field_done;
  logic [31:0] skip_dec;
  logic        ext_hdr;
  logic        go;
  step_t       go_to;
  logic [7:0]  hb;

  assign s1_take   = s1_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  always_comb begin
    hb           = s1_beat.header_byte;
    cur_step     = s1_beat.restart ? FS_MAGIC : field_step_r;
    cur_bif      = s1_beat.restart ? 4'd0 : byte_in_field_r;
    cur_skip     = s1_beat.restart ? 32'd0 : skip_count_r;
    cur_shift    = s1_beat.restart ? 32'd0 : field_shift_r;
    cur_version  = s1_beat.restart ? 16'd0 : version_word_r;
    cur_flags    = s1_beat.restart ? 32'd0 : flags_word_r;
    cur_consumed = s1_beat.restart ? 32'd0 : consumed_r;
    cur_status   = s1_beat.restart ? lhp_pkg::ST_BUSY : status_r;

    shift_cat = {cur_shift[23:0], hb};
    bif_inc   = cur_bif + 4'd1;
    skip_dec  = (cur_skip != 32'd0) ? cur_skip - 32'd1 : cur_skip;
    ext_hdr   = cur_version >= lhp_pkg::EXT_VERSION;

    case (cur_step)
      FS_MAGIC:                          field_len = lhp_pkg::MAGIC_LEN;
      FS_VER, FS_LIBVER, FS_NEED:        field_len = 4'd2;
      FS_METHOD, FS_LEVEL, FS_NAMELEN:   field_len = 4'd1;
      FS_NAME, FS_XDATA:                 field_len = 4'd1;
      default:                           field_len = 4'd4;
    endcase
    field_done = bif_inc >= field_len;

    field_step_nxt    = cur_step;
    byte_in_field_nxt = cur_bif;
    skip_count_nxt    = cur_skip;
    field_shift_nxt   = cur_shift;
    version_word_nxt  = cur_version;
    flags_word_nxt    = cur_flags;
    consumed_nxt      = cur_consumed;
    status_nxt        = cur_status;
    go                = 1'b0;
    go_to             = FS_MAGIC;

    if (cur_status == lhp_pkg::ST_BUSY) begin
      consumed_nxt = (&cur_consumed) ? cur_consumed : cur_consumed + 32'd1;
      case (cur_step)
        FS_MAGIC: begin
          if (cur_bif >= lhp_pkg::MAGIC_LEN || hb != lhp_pkg::magic_byte(cur_bif)) begin
            status_nxt = lhp_pkg::ST_BAD_MAGIC;
          end else if (cur_bif == lhp_pkg::MAGIC_LEN - 4'd1) begin
            go    = 1'b1;
            go_to = FS_VER;
          end else begin
            byte_in_field_nxt = bif_inc;
          end
        end
        FS_NAME, FS_XDATA: begin
          skip_count_nxt = skip_dec;
          if (skip_dec == 32'd0) begin
            go    = 1'b1;
            go_to = (cur_step == FS_NAME) ? FS_HCHK : FS_XCHK;
          end
        end
        default: begin
          field_shift_nxt   = shift_cat;
          byte_in_field_nxt = bif_inc;
          if (field_done) begin
            case (cur_step)
              FS_VER: begin
                version_word_nxt = shift_cat[15:0];
                if (shift_cat[15:0] < lhp_pkg::MIN_VERSION) begin
                  status_nxt = lhp_pkg::ST_BAD_VERSION;
                end else begin
                  go = 1'b1; go_to = FS_LIBVER;
                end
              end
              FS_LIBVER: begin
                go = 1'b1; go_to = ext_hdr ? FS_NEED : FS_METHOD;
              end
              FS_NEED: begin
                if (shift_cat > {16'd0, max_needed} ||
                    shift_cat < {16'd0, lhp_pkg::MIN_VERSION}) begin
                  status_nxt = lhp_pkg::ST_BAD_NEEDED;
                end else begin
                  go = 1'b1; go_to = FS_METHOD;
                end
              end
              FS_METHOD: begin
                go = 1'b1; go_to = ext_hdr ? FS_LEVEL : FS_FLAGS;
              end
              FS_LEVEL: begin
                go = 1'b1; go_to = FS_FLAGS;
              end
              FS_FLAGS: begin
                flags_word_nxt = shift_cat;
                go = 1'b1;
                go_to = ((shift_cat & lhp_pkg::FL_FILTER) != 32'd0) ? FS_FILTER : FS_MODE;
              end
              FS_FILTER: begin
                go = 1'b1; go_to = FS_MODE;
              end
              FS_MODE: begin
                go = 1'b1; go_to = FS_MTIME;
              end
              FS_MTIME: begin
                go = 1'b1; go_to = ext_hdr ? FS_MTIMEHI : FS_NAMELEN;
              end
              FS_MTIMEHI: begin
                go = 1'b1; go_to = FS_NAMELEN;
              end
              FS_NAMELEN: begin
                go = 1'b1;
                if (shift_cat != 32'd0) begin
                  go_to          = FS_NAME;
                  skip_count_nxt = shift_cat;
                end else begin
                  go_to = FS_HCHK;
                end
              end
              FS_HCHK: begin
                if ((cur_flags & lhp_pkg::FL_EXTRA) != 32'd0) begin
                  go = 1'b1; go_to = FS_XLEN;
                end else if ((cur_flags & (lhp_pkg::FL_CRC_C | lhp_pkg::FL_ADLER_C)) != 32'd0) begin
                  status_nxt = lhp_pkg::ST_BAD_CHECKSUM;
                end else begin
                  status_nxt = lhp_pkg::ST_DONE;
                end
              end
              FS_XLEN: begin
                go = 1'b1;
                if (shift_cat != 32'd0) begin
                  go_to          = FS_XDATA;
                  skip_count_nxt = shift_cat;
                end else begin
                  go_to = FS_XCHK;
                end
              end
              FS_XCHK: begin
                if ((cur_flags & (lhp_pkg::FL_CRC_C | lhp_pkg::FL_ADLER_C)) != 32'd0) begin
                  status_nxt = lhp_pkg::ST_BAD_CHECKSUM;
                end else begin
                  status_nxt = lhp_pkg::ST_DONE;
                end
              end
              default: begin
                go = 1'b1; go_to = FS_MAGIC;
              end
            endcase
          end
        end
      endcase
    end

    if (go) begin
      field_step_nxt    = go_to;
      byte_in_field_nxt = 4'd0;
      field_shift_nxt   = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_step_r    <= FS_MAGIC;
      byte_in_field_r <= 4'd0;
      skip_count_r    <= 32'd0;
      field_shift_r   <= 32'd0;
      version_word_r  <= 16'd0;
      flags_word_r    <= 32'd0;
      consumed_r      <= 32'd0;
      status_r        <= lhp_pkg::ST_BUSY;
      out_valid_r     <= 1'b0;
    end else begin
      if (s1_take) begin
        field_step_r    <= field_step_nxt;
        byte_in_field_r <= byte_in_field_nxt;
        skip_count_r    <= skip_count_nxt;
        field_shift_r   <= field_shift_nxt;
        version_word_r  <= version_word_nxt;
        flags_word_r    <= flags_word_nxt;
        consumed_r      <= consumed_nxt;
        status_r        <= status_nxt;
        out_beat_r.status             <= status_nxt;
        out_beat_r.header_length      <= consumed_nxt;
        out_beat_r.header_flags       <= flags_word_nxt;
        out_beat_r.block_has_checksum <=
          ((flags_word_nxt & (lhp_pkg::FL_ADLER_D | lhp_pkg::FL_CRC_D)) != 32'd0);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // a finished or failed header stays put until a restart
  a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && !s1_beat.restart && status_r != lhp_pkg::ST_BUSY)
      |=> (status_r == $past(status_r) && consumed_r == $past(consumed_r)))
    else $error("parser state moved after header end");

  // byte count never goes down without a restart
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && !s1_beat.restart) |=> consumed_r >= $past(consumed_r))
    else $error("byte count went backwards");

  // a skip field is only entered with bytes left to skip
  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (field_step_r == FS_NAME || field_step_r == FS_XDATA) |-> skip_count_r != 32'd0)
    else $error("skip field with zero count");

  // result register mirrors the state it was computed with
  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_take |=> (out_beat_r.status == status_r && out_beat_r.header_length == consumed_r))
    else $error("result beat differs from parser state");

endmodule

@@ sv/lzop_header_parser.sv @@
`timescale 1ns / 1ps
// lzop_header_parser: top level of the lzop file header parser
// depends on lhp_pkg, lhp_in_if, lhp_out_if, lhp_in_stage, lhp_walker
//
//   channel  | dir | handshake      | beat contents
//   ---------+-----+----------------+-------------------------------------------
//   in_bus   | in  | valid / ready  | header_byte, restart
//   out_bus  | out | valid / ready  | status, header_length, header_flags,
//            |     |                | block_has_checksum
//   cfg_*    | in  | cfg_wr_en      | cfg_wr_data = max needed version
//
// one byte beat per cycle sustained while out_ready stays high; a result beat is
// offered once its byte beat has passed the input register, then the field
// sequencer into the result register
// every byte beat gives exactly one result beat
// reset is synchronous on rst_n low: parser back at the magic field, both
// stages empty, max needed version back to 0x1030
// out_ready low with a result waiting holds the result register; in_ready drops
// in that same cycle when the input register is full, else after one more beat

module lzop_header_parser (
  input  logic             clk,
  input  logic             rst_n,
  lhp_in_if.sink           in_bus,
  lhp_out_if.source        out_bus,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data
);

  logic [15:0] max_needed_r;

  lhp_pkg::in_beat_t  in_beat;
  lhp_pkg::in_beat_t  s1_beat;
  lhp_pkg::out_beat_t res_beat;
  logic               s1_valid;
  logic               s1_take;

  // greatest version needed to extract that the parser accepts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_needed_r <= lhp_pkg::DEFAULT_NEEDED;
    end else if (cfg_wr_en) begin
      max_needed_r <= cfg_wr_data;
    end
  end

  assign in_beat.header_byte = in_bus.header_byte;
  assign in_beat.restart     = in_bus.restart;

  // input register: parts the byte stream from the sequencer
  lhp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .in_beat  (in_beat),
    .s1_valid (s1_valid),
    .s1_take  (s1_take),
    .s1_beat  (s1_beat)
  );

  // field sequencer plus result register
  lhp_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_needed (max_needed_r),
    .s1_valid   (s1_valid),
    .s1_beat    (s1_beat),
    .s1_take    (s1_take),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_beat   (res_beat)
  );

  // result beat onto the output channel
  assign out_bus.status             = res_beat.status;
  assign out_bus.header_length      = res_beat.header_length;
  assign out_bus.header_flags       = res_beat.header_flags;
  assign out_bus.block_has_checksum = res_beat.block_has_checksum;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for lzop_header_parser, drives header byte beats
// in random bursts against a stalling receiver and checks every result beat
// depends on lhp_pkg, lhp_in_if, lhp_out_if and the lzop_header_parser rtl

module tb_top;

  // header fields in the order the parser walks them
  typedef enum logic [4:0] {
    FS_MAGIC, FS_VER, FS_LIBVER, FS_NEED, FS_METHOD, FS_LEVEL, FS_FLAGS, FS_FILTER,
    FS_MODE, FS_MTIME, FS_MTIMEHI, FS_NAMELEN, FS_NAME, FS_HCHK, FS_XLEN, FS_XDATA,
    FS_XCHK
  } field_t;

  // ways a generated header can be spoiled
  typedef enum int {
    F_NONE, F_MAGIC, F_VERSION, F_NEEDED, F_CHECKSUM, F_TRUNC
  } fault_t;

  localparam logic [7:0] SIGNATURE [0:8] = '{8'h89, 8'h4c, 8'h5a, 8'h4f, 8'h00,
                                            8'h0d, 8'h0a, 8'h1a, 8'h0a};
  localparam int PHASE_BEATS = 118;
  localparam int PHASES      = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  lhp_in_if  in_bus ();
  lhp_out_if out_bus ();

  lzop_header_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // header walk model: own copy of the parser state and the register
  // ---------------------------------------------------------------------------
  logic [15:0]      hdr_max_needed;
  field_t           hdr_step;
  logic [3:0]       hdr_idx;
  logic [31:0]      hdr_skip;
  logic [31:0]      hdr_shift;
  logic [15:0]      hdr_version;
  logic [31:0]      hdr_flags;
  logic [31:0]      hdr_count;
  lhp_pkg::status_t hdr_status;

  task automatic clear_walk();
    hdr_step    = FS_MAGIC;
    hdr_idx     = '0;
    hdr_skip    = '0;
    hdr_shift   = '0;
    hdr_version = '0;
    hdr_flags   = '0;
    hdr_count   = '0;
    hdr_status  = lhp_pkg::ST_BUSY;
  endtask

  task automatic enter_field(input field_t s);
    hdr_step  = s;
    hdr_idx   = '0;
    hdr_shift = '0;
  endtask

  // end of header: compressed-block checksums are not supported
  task automatic close_header();
    if ((hdr_flags & (lhp_pkg::FL_CRC_C | lhp_pkg::FL_ADLER_C)) != 0)
      hdr_status = lhp_pkg::ST_BAD_CHECKSUM;
    else hdr_status = lhp_pkg::ST_DONE;
  endtask

  // one byte beat in, the result beat it should produce out
  task automatic parse_byte(input logic [7:0] b, input logic restart,
                            output lhp_pkg::out_beat_t r);
    logic        ext;
    logic [3:0]  flen;
    logic [31:0] v;
    if (restart) clear_walk();
    if (hdr_status == lhp_pkg::ST_BUSY) begin
      if (hdr_count != 32'hFFFF_FFFF) hdr_count = hdr_count + 32'd1;
      case (hdr_step)
        FS_MAGIC: begin
          // first differing signature byte is fatal
          if (b != SIGNATURE[hdr_idx]) hdr_status = lhp_pkg::ST_BAD_MAGIC;
          else if (hdr_idx == 4'd8) enter_field(FS_VER);
          else hdr_idx = hdr_idx + 4'd1;
        end
        FS_NAME, FS_XDATA: begin
          if (hdr_skip != 0) hdr_skip = hdr_skip - 32'd1;
          if (hdr_skip == 0) enter_field(hdr_step == FS_NAME ? FS_HCHK : FS_XCHK);
        end
        default: begin
          case (hdr_step)
            FS_VER, FS_LIBVER, FS_NEED:     flen = 4'd2;
            FS_METHOD, FS_LEVEL, FS_NAMELEN: flen = 4'd1;
            default:                         flen = 4'd4;
          endcase
          hdr_shift = {hdr_shift[23:0], b};
          hdr_idx   = hdr_idx + 4'd1;
          if (hdr_idx >= flen) begin
            v   = hdr_shift;
            ext = (hdr_version >= lhp_pkg::EXT_VERSION);
            case (hdr_step)
              FS_VER: begin
                hdr_version = v[15:0];
                if (hdr_version < lhp_pkg::MIN_VERSION) hdr_status = lhp_pkg::ST_BAD_VERSION;
                else enter_field(FS_LIBVER);
              end
              FS_LIBVER: enter_field(ext ? FS_NEED : FS_METHOD);
              FS_NEED: begin
                if (v > {16'h0, hdr_max_needed} || v < {16'h0, lhp_pkg::MIN_VERSION})
                  hdr_status = lhp_pkg::ST_BAD_NEEDED;
                else enter_field(FS_METHOD);
              end
              FS_METHOD:  enter_field(ext ? FS_LEVEL : FS_FLAGS);
              FS_LEVEL:   enter_field(FS_FLAGS);
              FS_FLAGS: begin
                hdr_flags = v;
                enter_field((v & lhp_pkg::FL_FILTER) != 0 ? FS_FILTER : FS_MODE);
              end
              FS_FILTER:  enter_field(FS_MODE);
              FS_MODE:    enter_field(FS_MTIME);
              FS_MTIME:   enter_field(ext ? FS_MTIMEHI : FS_NAMELEN);
              FS_MTIMEHI: enter_field(FS_NAMELEN);
              FS_NAMELEN: begin
                // zero length name: go straight to the header checksum
                if (v != 0) begin
                  enter_field(FS_NAME);
                  hdr_skip = v;
                end else enter_field(FS_HCHK);
              end
              FS_HCHK: begin
                if ((hdr_flags & lhp_pkg::FL_EXTRA) != 0) enter_field(FS_XLEN);
                else close_header();
              end
              FS_XLEN: begin
                if (v != 0) begin
                  enter_field(FS_XDATA);
                  hdr_skip = v;
                end else enter_field(FS_XCHK);
              end
              FS_XCHK: close_header();
              default: enter_field(FS_MAGIC);
            endcase
          end
        end
      endcase
    end
    r.status             = hdr_status;
    r.header_length      = hdr_count;
    r.header_flags       = hdr_flags;
    r.block_has_checksum = ((hdr_flags & (lhp_pkg::FL_ADLER_D | lhp_pkg::FL_CRC_D)) != 0);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus store and header builder
  // ---------------------------------------------------------------------------
  lhp_pkg::in_beat_t  byte_q [$];     // beats waiting for the driver
  lhp_pkg::out_beat_t result_q [$];   // predicted result beats, oldest first
  logic [7:0]         frame_q [$];    // bytes of the header being built
  int                 queued_beats = 0;

  task automatic put_beat(input logic [7:0] b, input logic rs);
    byte_q.push_back('{header_byte: b, restart: rs});
    queued_beats++;
  endtask

  // big-endian field into the frame under construction
  task automatic put_be(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) frame_q.push_back(v[8*i +: 8]);
  endtask

  task automatic queue_header(input fault_t fault);
    logic [15:0] ver;
    logic [15:0] need;
    logic [31:0] flags;
    logic [31:0] xlen;
    int          nlen;
    int          cut;
    int          pos;
    logic        ext;
    logic        rs;
    frame_q.delete();
    for (int i = 0; i < 9; i++) frame_q.push_back(SIGNATURE[i]);
    if (fault == F_MAGIC) begin
      pos = $urandom_range(8, 0);
      frame_q[pos] = SIGNATURE[pos] ^ 8'($urandom_range(255, 1));
    end
    // extended layout only when a needed version can pass, or to break it
    ext = (fault == F_NEEDED) ||
          (hdr_max_needed >= lhp_pkg::MIN_VERSION && $urandom_range(1, 0));
    if (fault == F_VERSION) ver = 16'($urandom_range(16'h08FF, 0));
    else if (ext && $urandom_range(1, 0)) ver = 16'($urandom_range(16'h20A0, 16'h0940));
    else if (ext) ver = 16'($urandom_range(16'hFFFF, 16'h0940));
    else ver = 16'($urandom_range(16'h093F, 16'h0900));
    put_be({16'h0, ver}, 2);
    put_be($urandom, 2);
    if (ext) begin
      if (fault != F_NEEDED) need = 16'($urandom_range(hdr_max_needed, 16'h0900));
      else if (hdr_max_needed != 16'hFFFF && $urandom_range(1, 0))
        need = 16'($urandom_range(16'hFFFF, int'(hdr_max_needed) + 1));
      else need = 16'($urandom_range(16'h08FF, 0));
      put_be({16'h0, need}, 2);
    end
    put_be($urandom, 1);
    if (ext) put_be($urandom, 1);
    flags = $urandom & ~(lhp_pkg::FL_ADLER_C | lhp_pkg::FL_CRC_C);
    if (fault == F_CHECKSUM) begin
      case ($urandom_range(2, 0))
        0:       flags = flags | lhp_pkg::FL_ADLER_C;
        1:       flags = flags | lhp_pkg::FL_CRC_C;
        default: flags = flags | lhp_pkg::FL_ADLER_C | lhp_pkg::FL_CRC_C;
      endcase
    end
    put_be(flags, 4);
    if ((flags & lhp_pkg::FL_FILTER) != 0) put_be($urandom, 4);
    put_be($urandom, 4);
    put_be($urandom, 4);
    if (ext) put_be($urandom, 4);
    // name: often empty, rarely long
    case ($urandom_range(31, 0))
      0:              nlen = $urandom_range(255, 128);
      1, 2, 3, 4, 5,
      6, 7, 8, 9:     nlen = 0;
      default:        nlen = $urandom_range(6, 1);
    endcase
    put_be(nlen, 1);
    repeat (nlen) put_be($urandom, 1);
    put_be($urandom, 4);
    if ((flags & lhp_pkg::FL_EXTRA) != 0) begin
      case ($urandom_range(31, 0))
        0:             xlen = $urandom_range(120, 33);
        1, 2, 3, 4, 5,
        6, 7, 8:       xlen = 0;
        default:       xlen = $urandom_range(6, 1);
      endcase
      put_be(xlen, 4);
      repeat (xlen) put_be($urandom, 1);
      put_be($urandom, 4);
    end
    if (fault == F_TRUNC) cut = $urandom_range(frame_q.size() - 1, 1);
    else cut = frame_q.size();
    // most headers start with a restart; the rest continue or get ignored
    rs = ($urandom_range(9, 0) != 0);
    for (int i = 0; i < cut; i++) put_beat(frame_q[i], rs && (i == 0));
    // trailing bytes after the header end must change nothing
    repeat ($urandom_range(3, 0)) put_beat(8'($urandom), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of beats with random gaps, changes on the falling edge
  // ---------------------------------------------------------------------------
  logic byte_taken = 1'b0;
  int   burst_left = 8;
  int   gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || byte_taken) begin
      byte_taken <= 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        in_bus.valid       <= 1'b1;
        in_bus.header_byte <= byte_q[0].header_byte;
        in_bus.restart     <= byte_q[0].restart;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(24, 1);
          gap_left   = ($urandom_range(4, 0) == 0) ? 0 : $urandom_range(6, 1);
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: ready follows a 16-bit mask that is redrawn now and then
  // ---------------------------------------------------------------------------
  int          stall_age = 0;
  logic [15:0] stall_mask = 16'hFFFF;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (stall_age == 0) begin
        stall_age  = $urandom_range(96, 16);
        // a quarter of the stretches never stall
        stall_mask = ($urandom_range(3, 0) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      stall_age--;
      out_bus.ready <= stall_mask[stall_age[3:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // scoreboard: check result beats, then predict from accepted byte beats
  // ---------------------------------------------------------------------------
  int fails = 0;
  int checked = 0;
  int status_hits [6];

  always @(posedge clk) begin
    lhp_pkg::out_beat_t want;
    lhp_pkg::out_beat_t got;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.status, out_bus.header_length, out_bus.header_flags,
               out_bus.block_has_checksum};
        if (result_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result beat status %0d length %0h flags %0h chk %0b",
                   $time, got.status, got.header_length, got.header_flags,
                   got.block_has_checksum);
        end else begin
          want = result_q.pop_front();
          checked++;
          if (got !== want) begin
            fails++;
            $display("%0t: mismatch expected status %0d length %0h flags %0h chk %0b",
                     $time, want.status, want.header_length, want.header_flags,
                     want.block_has_checksum);
            $display("%0t:          actual   status %0d length %0h flags %0h chk %0b",
                     $time, got.status, got.header_length, got.header_flags,
                     got.block_has_checksum);
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        parse_byte(in_bus.header_byte, in_bus.restart, want);
        result_q.push_back(want);
        status_hits[want.status]++;
        byte_q.delete(0);
        byte_taken <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run control: reset, directed beats, then phases of random headers
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] setting;
    int          goal;
    int          pick;
    in_bus.valid       = 1'b0;
    in_bus.header_byte = '0;
    in_bus.restart     = 1'b0;
    out_bus.ready      = 1'b0;
    hdr_max_needed     = lhp_pkg::DEFAULT_NEEDED;
    clear_walk();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: bad first byte straight after reset, then ignored bytes
    put_beat(8'h00, 1'b0);
    put_beat(8'hFF, 1'b0);
    put_beat(8'h89, 1'b0);
    // restart, signature broken in the middle
    put_beat(8'h89, 1'b1);
    put_beat(8'h4c, 1'b0);
    put_beat(8'h5a, 1'b0);
    put_beat(8'h4f, 1'b0);
    put_beat(8'hFF, 1'b0);
    // restart, good signature, version just under the minimum
    for (int i = 0; i < 9; i++) put_beat(SIGNATURE[i], i == 0);
    put_beat(8'h08, 1'b0);
    put_beat(8'hFF, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        // register only changes with nothing in flight
        while (byte_q.size() != 0 || result_q.size() != 0) @(posedge clk);
        case (ph)
          1:       setting = 16'hFFFF;
          2:       setting = 16'h0000;
          3:       setting = lhp_pkg::MIN_VERSION;
          4:       setting = 16'($urandom_range(16'h3000, 16'h0900));
          default: setting = lhp_pkg::DEFAULT_NEEDED;
        endcase
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= setting;
        hdr_max_needed = setting;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
      end
      goal = queued_beats + PHASE_BEATS;
      while (queued_beats < goal) begin
        pick = $urandom_range(99, 0);
        if (pick < 10) begin
          // noise: a few random bytes after a restart
          put_beat(8'($urandom), 1'b1);
          repeat ($urandom_range(4, 0)) put_beat(8'($urandom), 1'b0);
        end else begin
          queue_header(pick < 50 ? F_NONE :
                       pick < 60 ? F_MAGIC :
                       pick < 70 ? F_VERSION :
                       pick < 80 ? F_NEEDED :
                       pick < 90 ? F_CHECKSUM : F_TRUNC);
        end
      end
    end

    while (byte_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("checked %0d result beats across %0d max needed version settings",
             checked, PHASES);
    $display("status mix: busy %0d done %0d magic %0d version %0d needed %0d checksum %0d",
             status_hits[lhp_pkg::ST_BUSY], status_hits[lhp_pkg::ST_DONE],
             status_hits[lhp_pkg::ST_BAD_MAGIC], status_hits[lhp_pkg::ST_BAD_VERSION],
             status_hits[lhp_pkg::ST_BAD_NEEDED], status_hits[lhp_pkg::ST_BAD_CHECKSUM]);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("%0t: run timed out", $time);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
